>>> hdl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/smse_pkg.sv
`default_nettype none
package smse_pkg;
  typedef enum logic [3:0] {
    ST_LOAD, ST_DIV, ST_RD, ST_SQ, ST_ACC, ST_VDIV, ST_SQRT, ST_OUT
  } state_t;
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SINGLE = 2'd1;
  localparam logic [1:0] STATUS_DROP = 2'd2;
  typedef struct packed {
    logic load;
    logic div_start;
    logic pass_start;
    logic rd;
    logic sq;
    logic acc;
    logic vdiv_start;
    logic sqrt_start;
    logic clear;
  } cmd_t;
  typedef struct packed {
    logic div_done;
    logic pass_end;
    logic vdiv_done;
    logic sqrt_done;
  } stat_t;
endpackage
`default_nettype wire

>>> hdl/smse_ctrl.sv
`default_nettype none
module smse_ctrl
  import smse_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  last_sample,
  output logic       out_valid,
  input  wire logic  out_ready,
  output cmd_t       cmd,
  input  wire stat_t stat
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_sample) begin
            cmd.div_start = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: if (stat.div_done) begin
        cmd.pass_start = 1'b1;
        state_next = ST_RD;
      end
      ST_RD: begin
        if (stat.pass_end) begin
          cmd.vdiv_start = 1'b1;
          state_next = ST_VDIV;
        end else begin
          cmd.rd = 1'b1;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        state_next = ST_RD;
      end
      ST_VDIV: if (stat.vdiv_done) begin
        cmd.sqrt_start = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: if (stat.sqrt_done) state_next = ST_OUT;
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/smse_datapath.sv
`default_nettype none
module smse_datapath
  import smse_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic signed [31:0] sample,
  output logic signed [31:0]      mean,
  output logic [31:0]             std_dev,
  output logic [10:0]             sample_total,
  output logic [1:0]              status
);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = 32 + CW;

  logic [31:0] store [MAX_SAMPLES];
  logic [31:0] rd_data;
  logic signed [SW-1:0] running_sum;
  logic [CW-1:0] sample_count;
  logic overflow_seen;
  logic [CW-1:0] rd_ptr;
  logic [63:0] deviation_sum;
  logic [63:0] term;
  logic [32:0] ad;

  always_ff @(posedge clk) begin
    if (cmd.load && sample_count < CW'(MAX_SAMPLES)) store[sample_count[AW-1:0]] <= sample;
    if (cmd.rd) rd_data <= store[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      running_sum <= '0;
      sample_count <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.load) begin
      if (sample_count < CW'(MAX_SAMPLES)) begin
        running_sum <= running_sum + SW'(sample);
        sample_count <= sample_count + 1'b1;
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // mean: signed restoring divide, one quotient bit per cycle
  logic [SW-1:0] dq, dr;
  logic [$clog2(SW+1)-1:0] dcnt;
  logic dbusy, dneg;
  logic [SW:0] dtrial;
  assign dtrial = {dr, dq[SW-1]} - {{(SW+1-CW){1'b0}}, sample_count};
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
      dcnt <= '0;
    end else if (dbusy) begin
      if (dcnt == ($clog2(SW+1))'(SW - 1)) dbusy <= 1'b0;
      dcnt <= dcnt + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dneg <= (cmd.load && sample_count < CW'(MAX_SAMPLES)) ?
              (running_sum + SW'(sample)) < 0 : running_sum < 0;
      dq <= (cmd.load && sample_count < CW'(MAX_SAMPLES)) ?
            ((running_sum + SW'(sample)) < 0 ? -(running_sum + SW'(sample))
             : (running_sum + SW'(sample)))
            : (running_sum < 0 ? -running_sum : running_sum);
      dr <= '0;
    end else if (dbusy) begin
      if (!dtrial[SW]) begin
        dr <= dtrial[SW-1:0];
        dq <= {dq[SW-2:0], 1'b1};
      end else begin
        dr <= {dr[SW-2:0], dq[SW-1]};
        dq <= {dq[SW-2:0], 1'b0};
      end
    end
  end
  logic dbusy_q;
  always_ff @(posedge clk) begin
    if (rst) dbusy_q <= 1'b0;
    else dbusy_q <= dbusy;
  end
  assign stat.div_done = dbusy_q && !dbusy;
  always_ff @(posedge clk) begin
    if (stat.div_done) mean <= dneg ? -dq[31:0] : dq[31:0];
  end

  // deviation pass
  assign stat.pass_end = (rd_ptr == sample_count);
  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      rd_ptr <= '0;
      deviation_sum <= '0;
    end else begin
      if (cmd.rd) rd_ptr <= rd_ptr + 1'b1;
      if (cmd.sq) ad <= ($signed(rd_data) > mean) ?
          33'($signed({rd_data[31], rd_data}) - $signed({mean[31], mean})) :
          33'($signed({mean[31], mean}) - $signed({rd_data[31], rd_data}));
      if (cmd.acc) deviation_sum <= (deviation_sum + term < deviation_sum) ? '1
                                    : deviation_sum + term;
    end
  end
  logic [65:0] sqw;
  assign sqw = ad * ad;
  assign term = 64'(sqw >> 16);

  // variance divide: 64 / count-1
  logic [63:0] vq;
  logic [CW-1:0] vr;
  logic [CW-1:0] vden;
  logic [6:0] vcnt;
  logic vbusy, vbusy_q;
  logic [CW:0] vtrial;
  assign vtrial = {vr, vq[63]} - {1'b0, vden};
  always_ff @(posedge clk) begin
    if (rst) begin
      vbusy <= 1'b0;
      vbusy_q <= 1'b0;
    end else begin
      vbusy_q <= vbusy;
      if (cmd.vdiv_start) begin
        vbusy <= 1'b1;
        vcnt <= '0;
      end else if (vbusy) begin
        if (vcnt == 7'd63) vbusy <= 1'b0;
        vcnt <= vcnt + 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.vdiv_start) begin
      vq <= deviation_sum;
      vr <= '0;
      vden <= (sample_count < CW'(2)) ? CW'(1) : sample_count - 1'b1;
    end else if (vbusy) begin
      if (!vtrial[CW]) begin
        vr <= vtrial[CW-1:0];
        vq <= {vq[62:0], 1'b1};
      end else begin
        vr <= {vr[CW-2:0], vq[63]};
        vq <= {vq[62:0], 1'b0};
      end
    end
  end
  assign stat.vdiv_done = vbusy_q && !vbusy;

  // square root of var<<16, two radicand bits per cycle
  logic [63:0] sn, sres, sbit;
  logic sbusy, sbusy_q, ssat;
  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
      sbusy_q <= 1'b0;
    end else begin
      sbusy_q <= sbusy;
      if (cmd.sqrt_start) sbusy <= 1'b1;
      else if (sbusy && (sbit == '0 || ssat)) sbusy <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sn <= {vq[47:0], 16'h0};
      ssat <= vq[63:48] != '0;
      sres <= '0;
      sbit <= 64'h1 << 62;
    end else if (sbusy && sbit != '0) begin
      if (sn >= sres + sbit) begin
        sn <= sn - (sres + sbit);
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
      sbit <= sbit >> 2;
    end
  end
  assign stat.sqrt_done = sbusy_q && !sbusy;

  always_comb begin
    sample_total = 11'(sample_count);
    if (sample_count < CW'(2)) std_dev = '0;
    else if (ssat) std_dev = '1;
    else std_dev = sres[31:0];
    if (overflow_seen) status = STATUS_DROP;
    else if (sample_count < CW'(2)) status = STATUS_SINGLE;
    else status = STATUS_OK;
  end
endmodule
`default_nettype wire

>>> hdl/sample_mean_std_estimator.sv
// Sample mean and standard deviation estimator.
// Input channel: sample (signed Q16.16) with last_sample, valid/ready.
// Samples are stored one transfer per cycle while loading.
// The transfer flagged last_sample starts the computation: a mean divide,
// a deviation pass that reads, squares and accumulates each stored sample,
// a variance divide and a square root, which ends early when the variance
// saturates.
// Input ready is low from the flagged transfer until the result is taken.
// Output channel: mean, std_dev, sample_total, status, valid/ready.
// The result holds while the receiver stalls; its transfer clears the
// sum, count and drop flag for the next set.
// Samples beyond MAX_SAMPLES are dropped and give status 2.
// Reset (synchronous) returns the block to loading with an empty set.
`default_nettype none
module sample_mean_std_estimator
  import smse_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] sample,
  input  wire logic               last_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      mean,
  output logic [31:0]             std_dev,
  output logic [10:0]             sample_total,
  output logic [1:0]              status
);
  cmd_t cmd;
  stat_t stat;

  smse_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last_sample,
    .out_valid, .out_ready, .cmd, .stat
  );

  smse_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk, .rst, .cmd, .stat, .sample, .mean, .std_dev, .sample_total, .status
  );
endmodule
`default_nettype wire

>>> hdl/smse_checker.sv
`default_nettype none
`include "assert_macros.svh"
module smse_checker
  import smse_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        last_sample,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] std_dev,
  input wire logic [1:0]  status
);
  `ASSERT_IMPL(a_excl, out_valid, !in_ready, "ready while result pending")
  `ASSERT_NEXT(a_last, in_valid && in_ready && last_sample, !in_ready, "took input after last")
  `ASSERT_IMPL(a_single, out_valid && status == STATUS_SINGLE, std_dev == 32'd0, "single std")
  `ASSERT_IMPL(a_stat, out_valid, status <= STATUS_DROP, "bad status")
  `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(std_dev), "result dropped")
endmodule
bind sample_mean_std_estimator smse_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .last_sample, .out_valid, .out_ready, .std_dev, .status
);
`default_nettype wire
